/* hdl/tkv_pkg.sv */
// shared types and constants for the tombstone key/value table
// no dependencies; used by tombstone_kv_table
package tkv_pkg;

  // request kinds, carried in s_tuser
  typedef enum logic [1:0] {
    REQ_UPSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_UPDATE = 2'd3
  } req_t;

  // result status, carried in m_tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // fixed field widths
  localparam int KEY_W   = 64;
  localparam int VALUE_W = 64;
  localparam int LIMIT_W = 7;

  // reset limit is capacity / 5, saturated to the register range
  localparam int LIMIT_DIVISOR = 5;
  localparam int LIMIT_MAX     = 127;

endpackage

/* hdl/tombstone_kv_table.sv */
// tombstone key/value table: top level with scan/compaction sequencer and entry memory
// depends on tkv_pkg
//
// Usage:
//   input stream s_*: s_tuser = request kind, s_tdata = key then new value.
//   result stream m_*: m_tdata = read value, m_tuser = status then compacted flag.
//   tombstone_limit_we/wdata write the compaction limit at any idle time.
// One item is worked on at a time; s_tready is high only while the sequencer idles.
// A lookup walks the used part of the table through one memory read port, one
// entry per cycle, with one compare unit: accept, scan, action, then the result
// sits in the output register.
// A delete that pushes the tombstone count over the limit then runs compaction
// over the same read port and one write port.
// The output register frees the input side: the next item is accepted while a
// result waits; the sequencer holds its finished result until m_tready frees the
// register. Reset empties the table (counts to zero, no memory clearing) and
// loads the limit with CAPACITY / 5 saturated to 127.
module tombstone_kv_table #(
  parameter int CAPACITY    = 64,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // input items
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [127:0]                  s_tdata,   // key_bytes[63:0], new_value[127:64]
  input  logic [1:0]                    s_tuser,   // req_type[1:0]
  // result items
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [63:0]                   m_tdata,   // read_value[63:0]
  output logic [2:0]                    m_tuser,   // status[1:0], compacted[2]
  // configuration
  input  logic                          tombstone_limit_we,
  input  logic [tkv_pkg::LIMIT_W-1:0]   tombstone_limit_wdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = KEY_BYTES * 8;
  localparam int VW = VALUE_BYTES * 8;
  localparam int MW = (CW > tkv_pkg::LIMIT_W) ? CW : tkv_pkg::LIMIT_W;
  localparam int LIMIT_RAW = CAPACITY / tkv_pkg::LIMIT_DIVISOR;
  localparam int LIMIT_RST = (LIMIT_RAW > tkv_pkg::LIMIT_MAX) ? tkv_pkg::LIMIT_MAX : LIMIT_RAW;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_COMPACT
  } state_t;

  // keep the bytes up to the first zero byte, within nbytes
  function automatic logic [63:0] str_form(logic [63:0] v, int nbytes);
    logic [63:0] r;
    logic        run;
    r   = '0;
    run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (i >= nbytes || v[8*i +: 8] == 8'd0) run = 1'b0;
      if (run) r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

  state_t                        state;
  tkv_pkg::req_t                 kind;
  logic [KW-1:0]                 key_r;
  logic [VW-1:0]                 val_r;
  logic [CW-1:0]                 used_entries;
  logic [CW-1:0]                 dead_entries;
  logic [tkv_pkg::LIMIT_W-1:0]   limit;
  logic [CW-1:0]                 idx;
  logic [CW-1:0]                 wn;
  logic                          pend;
  logic [AW-1:0]                 pend_idx;
  logic                          found;
  logic [AW-1:0]                 hit_idx;
  logic [VW-1:0]                 hit_val;
  logic                          out_valid;
  tkv_pkg::status_t              out_status;
  logic [VW-1:0]                 out_value;
  logic                          out_comp;

  // entry memory
  logic [KW-1:0]                 mem_key  [CAPACITY];
  logic [VW-1:0]                 mem_val  [CAPACITY];
  logic                          mem_dead [CAPACITY];
  logic [KW-1:0]                 rd_key;
  logic [VW-1:0]                 rd_val;
  logic                          rd_dead;

  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [KW-1:0]                 mem_wkey;
  logic [VW-1:0]                 mem_wval;
  logic                          mem_wdead;

  logic [63:0]                   key_form;
  logic [63:0]                   val_form;
  logic                          hit;
  logic                          more;
  logic                          out_free;
  logic                          out_load;
  logic                          is_full;
  logic [CW-1:0]                 dead_inc;
  logic                          do_compact;
  tkv_pkg::status_t              act_status;
  logic [VW-1:0]                 act_value;

  // input payload in string form
  assign key_form = str_form(s_tdata[63:0], KEY_BYTES);
  assign val_form = str_form(s_tdata[127:64], VALUE_BYTES);

  // handshake and shared compare
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = 64'(out_value);
  assign m_tuser  = {out_comp, out_status};
  assign out_free = !out_valid || m_tready;
  assign more     = (idx < used_entries);
  assign hit      = pend && !rd_dead && (rd_key == key_r);
  assign is_full  = (used_entries >= CAP_CNT);
  assign dead_inc = dead_entries + 1'b1;
  assign do_compact = (kind == tkv_pkg::REQ_DELETE) && found &&
                      (MW'(dead_inc) > MW'(limit));
  assign rd_addr  = idx[AW-1:0];
  // a finished result enters the output register
  assign out_load = out_free && (((state == S_ACT) && !do_compact) ||
                                 ((state == S_COMPACT) && !rd_en && !pend));

  // action result for the finished lookup
  always_comb begin
    act_status = tkv_pkg::ST_OK;
    act_value  = '0;
    unique case (kind)
      tkv_pkg::REQ_UPSERT: begin
        if (!found && is_full) act_status = tkv_pkg::ST_FULL;
      end
      tkv_pkg::REQ_GET: begin
        if (found) act_value = hit_val;
        else act_status = tkv_pkg::ST_NOT_FOUND;
      end
      tkv_pkg::REQ_DELETE, tkv_pkg::REQ_UPDATE: begin
        if (!found) act_status = tkv_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // memory read and write control
  always_comb begin
    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = hit_idx;
    mem_wkey  = key_r;
    mem_wval  = val_r;
    mem_wdead = 1'b0;
    unique case (state)
      S_SCAN: begin
        rd_en = !hit && more;
      end
      S_ACT: begin
        if (out_free || do_compact) begin
          unique case (kind)
            tkv_pkg::REQ_UPSERT: begin
              if (found) begin
                mem_we = 1'b1;
              end else if (!is_full) begin
                mem_we = 1'b1;
                mem_wa = used_entries[AW-1:0];
              end
            end
            tkv_pkg::REQ_DELETE: begin
              mem_we    = found;
              mem_wval  = hit_val;
              mem_wdead = 1'b1;
            end
            tkv_pkg::REQ_UPDATE: begin
              mem_we = found;
            end
            tkv_pkg::REQ_GET: begin
              mem_we = 1'b0;
            end
          endcase
        end
      end
      S_COMPACT: begin
        rd_en    = more;
        mem_we   = pend && !rd_dead;
        mem_wa   = wn[AW-1:0];
        mem_wkey = rd_key;
        mem_wval = rd_val;
      end
      S_IDLE: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // entry memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[mem_wa]  <= mem_wkey;
      mem_val[mem_wa]  <= mem_wval;
      mem_dead[mem_wa] <= mem_wdead;
    end
  end

  // entry memory read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= mem_key[rd_addr];
      rd_val  <= mem_val[rd_addr];
      rd_dead <= mem_dead[rd_addr];
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      used_entries <= '0;
      dead_entries <= '0;
      limit        <= LIMIT_RST[tkv_pkg::LIMIT_W-1:0];
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      idx          <= '0;
      wn           <= '0;
      found        <= 1'b0;
    end else begin
      if (tombstone_limit_we) limit <= tombstone_limit_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && m_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind  <= tkv_pkg::req_t'(s_tuser);
            key_r <= key_form[KW-1:0];
            val_r <= val_form[VW-1:0];
            idx   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end
        // one entry read and one compare per cycle
        S_SCAN: begin
          if (hit) begin
            found   <= 1'b1;
            hit_idx <= pend_idx;
            hit_val <= rd_val;
            state   <= S_ACT;
          end else if (rd_en) begin
            idx      <= idx + 1'b1;
            pend     <= 1'b1;
            pend_idx <= idx[AW-1:0];
          end else begin
            found <= 1'b0;
            state <= S_ACT;
          end
        end
        // apply the request and post the result, or start compaction after a delete over the limit
        S_ACT: begin
          if (do_compact) begin
            dead_entries <= dead_inc;
            idx          <= '0;
            wn           <= '0;
            pend         <= 1'b0;
            state        <= S_COMPACT;
          end else if (out_free) begin
            out_status <= act_status;
            out_value  <= act_value;
            out_comp   <= 1'b0;
            state      <= S_IDLE;
            if (kind == tkv_pkg::REQ_UPSERT && !found && !is_full) begin
              used_entries <= used_entries + 1'b1;
            end
            if (kind == tkv_pkg::REQ_DELETE && found) dead_entries <= dead_inc;
          end
        end
        // move live entries down, one read and at most one write per cycle
        S_COMPACT: begin
          if (mem_we) wn <= wn + 1'b1;
          if (rd_en) begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else if (out_free) begin
            used_entries <= wn;
            dead_entries <= '0;
            out_status   <= tkv_pkg::ST_OK;
            out_value    <= '0;
            out_comp     <= 1'b1;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // tombstones never outnumber the used entries
  a_dead_le_used: assert property (@(posedge clk) disable iff (rst)
    dead_entries <= used_entries)
    else $error("tombstone count above used count");

  // used count stays within capacity
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used_entries <= CAP_CNT)
    else $error("used count above capacity");

  // compaction only reported on a successful delete
  a_comp_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == tkv_pkg::ST_OK))
    else $error("compaction flagged with error status");

  // failed requests return no value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != tkv_pkg::ST_OK) |-> (m_tdata == 64'd0))
    else $error("value returned with error status");

  // compaction leaves no tombstones behind
  a_comp_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT && !rd_en && !pend && out_free) |=> (dead_entries == '0))
    else $error("tombstones left after compaction");
`endif

endmodule

/* tb/tb_tombstone_kv_table.sv */
`timescale 1ns / 100ps
// self-checking testbench for tombstone_kv_table: directed and random request streams,
// a scoreboard class that models the table and compares every result item
// depends on tkv_pkg and tombstone_kv_table
module tb_tombstone_kv_table;

  localparam int TABLE_DEPTH = 64;
  localparam int N_KEY_BYTES = 8;
  localparam int N_VAL_BYTES = 8;
  localparam int LONG_HOLD = 600;
  localparam int POOL_MAX = 128;

  // directed keys: "AB", "AB" with junk after its end, all ones, empty with junk
  localparam logic [63:0] K_AB = 64'h0000_0000_0000_4241;
  localparam logic [63:0] K_AB_TAIL = 64'h5A5A_5A5A_5A00_4241;
  localparam logic [63:0] K_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] K_EMPTY_TAIL = 64'hFFFF_FFFF_FFFF_FF00;

  // table model and store of expected result items
  class kv_table_scoreboard;
    typedef struct packed {
      tkv_pkg::status_t status;
      logic [63:0]      read_value;
      logic             compacted;
    } answer_t;

    logic [63:0] entry_key [TABLE_DEPTH];
    logic [63:0] entry_val [TABLE_DEPTH];
    bit          entry_gone[TABLE_DEPTH];
    int unsigned used_cnt;
    int unsigned tomb_cnt;
    int unsigned limit;
    answer_t     expected_answers[$];
    int          errors;
    int          checked;
    int          compactions;
    int          full_answers;
    int          missing_answers;
    int          kind_count[4];

    function new();
      used_cnt = 0;
      tomb_cnt = 0;
      limit = TABLE_DEPTH / tkv_pkg::LIMIT_DIVISOR;
      if (limit > tkv_pkg::LIMIT_MAX) limit = tkv_pkg::LIMIT_MAX;
      errors = 0;
      checked = 0;
      compactions = 0;
      full_answers = 0;
      missing_answers = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_limit(logic [tkv_pkg::LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    // keep bytes up to the first zero byte, clear the rest
    function logic [63:0] string_form(logic [63:0] raw, int nbytes);
      logic [63:0] s;
      s = '0;
      for (int i = 0; i < nbytes; i++) begin
        if (raw[8*i +: 8] == 8'h00) break;
        s[8*i +: 8] = raw[8*i +: 8];
      end
      return s;
    endfunction

    function int find_live(logic [63:0] key);
      for (int i = 0; i < used_cnt; i++) begin
        if (!entry_gone[i] && entry_key[i] == key) return i;
      end
      return -1;
    endfunction

    // pack live entries to the front in order
    function void compact_entries();
      int n;
      n = 0;
      for (int i = 0; i < used_cnt; i++) begin
        if (!entry_gone[i]) begin
          entry_key[n] = entry_key[i];
          entry_val[n] = entry_val[i];
          entry_gone[n] = 1'b0;
          n++;
        end
      end
      used_cnt = n;
      tomb_cnt = 0;
    endfunction

    // work out the answer for an accepted request and queue it
    function void note_request(tkv_pkg::req_t kind, logic [63:0] key_raw,
                               logic [63:0] val_raw);
      answer_t     a;
      logic [63:0] key;
      logic [63:0] val;
      int          idx;
      key = string_form(key_raw, N_KEY_BYTES);
      val = string_form(val_raw, N_VAL_BYTES);
      a.status = tkv_pkg::ST_OK;
      a.read_value = '0;
      a.compacted = 1'b0;
      idx = find_live(key);
      kind_count[kind]++;
      case (kind)
        tkv_pkg::REQ_UPSERT: begin
          if (idx >= 0) begin
            entry_val[idx] = val;
          end else if (used_cnt >= TABLE_DEPTH) begin
            a.status = tkv_pkg::ST_FULL;
          end else begin
            entry_key[used_cnt] = key;
            entry_val[used_cnt] = val;
            entry_gone[used_cnt] = 1'b0;
            used_cnt++;
          end
        end
        tkv_pkg::REQ_GET: begin
          if (idx >= 0) a.read_value = entry_val[idx];
          else a.status = tkv_pkg::ST_NOT_FOUND;
        end
        tkv_pkg::REQ_DELETE: begin
          if (idx < 0) begin
            a.status = tkv_pkg::ST_NOT_FOUND;
          end else begin
            entry_gone[idx] = 1'b1;
            tomb_cnt++;
            if (tomb_cnt > limit) begin
              compact_entries();
              a.compacted = 1'b1;
            end
          end
        end
        default: begin
          if (idx < 0) a.status = tkv_pkg::ST_NOT_FOUND;
          else entry_val[idx] = val;
        end
      endcase
      if (a.status == tkv_pkg::ST_FULL) full_answers++;
      if (a.status == tkv_pkg::ST_NOT_FOUND) missing_answers++;
      if (a.compacted) compactions++;
      expected_answers.push_back(a);
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(logic [1:0] st, logic [63:0] rd, logic comp);
      answer_t a;
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: status %0d value %h compacted %0b",
                 $time, st, rd, comp);
        return;
      end
      a = expected_answers.pop_front();
      checked++;
      if (st !== a.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, a.status, st);
      end
      if (rd !== a.read_value) begin
        errors++;
        $display("%0t: read value expected %h got %h", $time, a.read_value, rd);
      end
      if (comp !== a.compacted) begin
        errors++;
        $display("%0t: compacted expected %0b got %0b", $time, a.compacted, comp);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [127:0] s_tdata;   // key_bytes[63:0], new_value[127:64]
  logic [1:0] s_tuser;     // req_type[1:0]
  logic m_tvalid;
  logic m_tready;
  logic [63:0] m_tdata;    // read_value[63:0]
  logic [2:0] m_tuser;     // status[1:0], compacted[2]
  logic tombstone_limit_we;
  logic [tkv_pkg::LIMIT_W-1:0] tombstone_limit_wdata;

  kv_table_scoreboard answers = new();
  logic [63:0] key_pool[POOL_MAX];
  int pool_used;
  bit long_hold_pending = 1'b0;
  int long_holds = 0;

  tombstone_kv_table #(
    .CAPACITY(TABLE_DEPTH),
    .KEY_BYTES(N_KEY_BYTES),
    .VALUE_BYTES(N_VAL_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .tombstone_limit_we(tombstone_limit_we),
    .tombstone_limit_wdata(tombstone_limit_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) answers.check_result(m_tuser[1:0], m_tdata, m_tuser[2]);
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    int seg_left;
    int mode;
    seg_left = 0;
    mode = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_holds++;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 200);
          mode = $urandom_range(0, 3);
        end
        seg_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // run limit
  initial begin
    #(64'd30_000_000);
    $display("Mismatches found");
    $finish;
  end

  // offer one item and wait until it is taken
  task automatic send_request(input tkv_pkg::req_t kind, input logic [63:0] key,
                              input logic [63:0] value);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    answers.note_request(kind, key, value);
  endtask

  task automatic go_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    go_idle();
    while (answers.pending() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [tkv_pkg::LIMIT_W-1:0] v);
    wait_drained();
    repeat (8) @(negedge clk);
    tombstone_limit_we <= 1'b1;
    tombstone_limit_wdata <= v;
    @(negedge clk);
    tombstone_limit_we <= 1'b0;
    answers.set_limit(v);
  endtask

  // pool of key strings, 0 to 8 nonzero bytes each
  task automatic fill_key_pool(input int n);
    logic [63:0] k;
    int len;
    pool_used = n;
    for (int j = 0; j < n; j++) begin
      k = '0;
      len = $urandom_range(0, 8);
      for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(1, 255));
      key_pool[j] = k;
    end
  endtask

  // mostly pool keys, sometimes with junk after the terminating zero byte
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    int len;
    if ($urandom_range(0, 99) < 15) return {$urandom, $urandom};
    k = key_pool[$urandom_range(0, pool_used - 1)];
    len = 0;
    while (len < 8 && k[8*len +: 8] != 8'h00) len++;
    if (len < 7 && $urandom_range(0, 1) == 1) k = k | ({$urandom, $urandom} << (8 * (len + 1)));
    return k;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int pos;
    v = {$urandom, $urandom};
    pos = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) v[8*pos +: 8] = 8'h00;
    return v;
  endfunction

  function automatic tkv_pkg::req_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return tkv_pkg::REQ_UPSERT;
    if (r < 60) return tkv_pkg::REQ_GET;
    if (r < 82) return tkv_pkg::REQ_DELETE;
    return tkv_pkg::REQ_UPDATE;
  endfunction

  // one random phase under one limit setting
  task automatic run_random_phase(input logic [tkv_pkg::LIMIT_W-1:0] lim, input int n_items,
                                  input int pool_size, input bit with_gaps,
                                  input bit with_hold);
    int burst_left;
    write_limit(lim);
    fill_key_pool(pool_size);
    if (with_hold) long_hold_pending = 1'b1;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < n_items; i++) begin
      // sender pause until all results are back
      if (i == n_items / 2) wait_drained();
      send_request(pick_kind(), pick_key(), pick_value());
      if (with_gaps) begin
        burst_left--;
        if (burst_left == 0) begin
          go_idle();
          repeat ($urandom_range(0, 6)) @(negedge clk);
          burst_left = $urandom_range(1, 16);
        end
      end
    end
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = tkv_pkg::REQ_UPSERT;
    tombstone_limit_we = 1'b0;
    tombstone_limit_wdata = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, extremes of keys and values, every request kind
    send_request(tkv_pkg::REQ_GET, K_AB, '0);
    send_request(tkv_pkg::REQ_DELETE, K_AB, '0);
    send_request(tkv_pkg::REQ_UPDATE, K_AB, 64'h1234);
    send_request(tkv_pkg::REQ_UPSERT, K_AB, 64'h1111);
    send_request(tkv_pkg::REQ_GET, K_AB_TAIL, K_ONES);
    send_request(tkv_pkg::REQ_UPSERT, K_ONES, K_ONES);
    send_request(tkv_pkg::REQ_GET, K_ONES, '0);
    send_request(tkv_pkg::REQ_UPSERT, 64'h0, 64'hFF00_1234_5678_9ABC);
    send_request(tkv_pkg::REQ_GET, K_EMPTY_TAIL, '0);
    send_request(tkv_pkg::REQ_UPDATE, K_AB, 64'h2222);
    send_request(tkv_pkg::REQ_GET, K_AB, '0);
    send_request(tkv_pkg::REQ_UPSERT, K_AB_TAIL, 64'h3333);
    send_request(tkv_pkg::REQ_GET, K_AB, '0);
    send_request(tkv_pkg::REQ_DELETE, K_AB, '0);
    send_request(tkv_pkg::REQ_GET, K_AB, '0);
    send_request(tkv_pkg::REQ_UPDATE, K_AB_TAIL, 64'h5555);
    send_request(tkv_pkg::REQ_UPSERT, K_AB, K_EMPTY_TAIL);
    send_request(tkv_pkg::REQ_GET, K_AB, '0);
    send_request(tkv_pkg::REQ_DELETE, K_ONES, '0);
    // limit of zero: the next delete compacts
    write_limit('0);
    send_request(tkv_pkg::REQ_DELETE, K_EMPTY_TAIL, '0);
    send_request(tkv_pkg::REQ_GET, K_AB, '0);
    send_request(tkv_pkg::REQ_UPSERT, K_ONES, 64'h0000_0000_0000_0005);
    send_request(tkv_pkg::REQ_DELETE, K_AB, '0);
    send_request(tkv_pkg::REQ_GET, K_ONES, '0);

    // random phases over several limits, the extremes among them
    run_random_phase(7'd12, 300, 40, 1'b1, 1'b0);
    run_random_phase(7'd0, 250, 16, 1'b0, 1'b1);
    run_random_phase(7'd127, 400, 110, 1'b1, 1'b0);
    run_random_phase(7'd64, 250, 80, 1'b1, 1'b0);
    run_random_phase(7'd3, 300, 24, 1'b1, 1'b0);
    run_random_phase(7'd63, 330, 48, 1'b0, 1'b0);

    // drain and let the sequencer settle
    wait_drained();
    repeat (2 * TABLE_DEPTH + 10) @(posedge clk);

    $display("run covered %0d upserts, %0d gets, %0d deletes, %0d updates",
             answers.kind_count[tkv_pkg::REQ_UPSERT], answers.kind_count[tkv_pkg::REQ_GET],
             answers.kind_count[tkv_pkg::REQ_DELETE], answers.kind_count[tkv_pkg::REQ_UPDATE]);
    $display("%0d results checked: %0d compactions, %0d full, %0d not found, %0d long holds",
             answers.checked, answers.compactions, answers.full_answers,
             answers.missing_answers, long_holds);
    if (answers.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
